// ----- sv/xsf_pkg.sv -----
// ----------------------------------------------------------------------------
// xsf_pkg: shared types and constants of the XOR sprite framebuffer
// Request and result payloads, opcodes and the control command bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package xsf_pkg;

    localparam int SCREEN_WIDTH_DEF  = 64;
    localparam int SCREEN_HEIGHT_DEF = 32;

    // Fixed by the payload: one line word, one sprite row, one coordinate.
    localparam int LINE_BITS      = 64;
    localparam int SPRITE_COLUMNS = 8;
    localparam int COORD_W        = 8;
    localparam int MOD_TAB_DEPTH  = 2 ** COORD_W;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_DRAW  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    typedef struct packed {
        logic [1:0]                opcode;
        logic [COORD_W-1:0]        x_pos;
        logic [COORD_W-1:0]        y_pos;
        logic [3:0]                row_index;
        logic [SPRITE_COLUMNS-1:0] sprite_byte;
        logic [4:0]                line_select;
    } t_in_req;

    typedef struct packed {
        logic                 collision;
        logic [LINE_BITS-1:0] line_pixels;
    } t_out_rsp;

    typedef struct packed {
        logic capture;
        logic commit;
    } t_ctrl_cmd;

endpackage

`default_nettype wire

// ----- sv/xsf_ctrl.sv -----
// ----------------------------------------------------------------------------
// xsf_ctrl: request sequencer of the XOR sprite framebuffer
// Two-state controller that owns both handshakes and the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module xsf_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  wire              i_out_stall,
    output xsf_pkg::t_ctrl_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_MODIFY = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   capture, commit;

    assign o_in_stall = (r_state != S_IDLE);
    assign capture    = (r_state == S_IDLE) && i_in_valid;
    // The write-back waits until the result register can take the new result.
    assign commit     = (r_state == S_MODIFY) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (capture) n_state = S_MODIFY;
            end
            S_MODIFY: begin
                if (commit) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_stall) begin
            n_out_valid = r_out_valid;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_cmd.capture = capture;
    assign o_cmd.commit  = commit;

    a_no_double_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        capture |=> !capture)
        else $error("request captured while the previous one is in flight");

    a_commit_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> o_out_valid)
        else $error("result valid not raised after write-back");

    a_modify_has_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MODIFY) |-> ($past(capture) || $past(r_state == S_MODIFY)))
        else $error("modify state entered without a captured request");

endmodule

`default_nettype wire

// ----- sv/xsf_datapath.sv -----
// ----------------------------------------------------------------------------
// xsf_datapath: line store and read-modify-write datapath
// Holds the display lines in a synchronous memory with per-line valid bits,
// the collision accumulator and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module xsf_datapath #(
    parameter int SCREEN_WIDTH  = xsf_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = xsf_pkg::SCREEN_HEIGHT_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  xsf_pkg::t_ctrl_cmd   i_cmd,
    input  xsf_pkg::t_in_req     i_req,
    output xsf_pkg::t_out_rsp    o_rsp
);

    localparam int LB    = xsf_pkg::LINE_BITS;
    localparam int CW    = xsf_pkg::COORD_W;
    localparam int ROW_W = $clog2(SCREEN_HEIGHT);
    localparam logic [LB-1:0] COL_MASK = ~({LB{1'b1}} >> SCREEN_WIDTH);

    // Residue tables for the raw coordinates, fixed at elaboration.
    logic [CW-1:0] x_mod_tab [xsf_pkg::MOD_TAB_DEPTH];
    logic [CW-1:0] y_mod_tab [xsf_pkg::MOD_TAB_DEPTH];

    for (genvar g = 0; g < xsf_pkg::MOD_TAB_DEPTH; g++) begin : g_mod_tab
        assign x_mod_tab[g] = CW'(g % SCREEN_WIDTH);
        assign y_mod_tab[g] = CW'(g % SCREEN_HEIGHT);
    end

    logic [LB-1:0]    mem [SCREEN_HEIGHT];
    logic             r_line_valid [SCREEN_HEIGHT];

    logic [1:0]       r_op;
    logic             r_idx_zero;
    logic             r_row_ok;
    logic             r_sel_ok;
    logic [LB-1:0]    r_mask;
    logic [ROW_W-1:0] r_addr;
    logic [LB-1:0]    r_rd_data;
    logic             r_rd_valid;
    logic             r_acc, n_acc;
    xsf_pkg::t_out_rsp r_rsp;

    // Request decode, ahead of the capture edge.
    logic [CW-1:0]    x_mod, y_mod, row_sum, sel_ext;
    logic             row_ok, sel_ok;
    logic [ROW_W-1:0] rd_addr;
    logic [LB-1:0]    mask;

    always_comb begin
        x_mod   = x_mod_tab[i_req.x_pos];
        y_mod   = y_mod_tab[i_req.y_pos];
        row_sum = y_mod + CW'(i_req.row_index);
        row_ok  = row_sum < CW'(SCREEN_HEIGHT);
        sel_ext = CW'(i_req.line_select);
        sel_ok  = sel_ext < CW'(SCREEN_HEIGHT);
        // Pixels that fall past the right edge shift out or are masked off.
        mask    = ({i_req.sprite_byte, {(LB - xsf_pkg::SPRITE_COLUMNS){1'b0}}} >> x_mod)
                  & COL_MASK;
        rd_addr = '0;
        if (i_req.opcode == xsf_pkg::OP_READ) begin
            if (sel_ok) rd_addr = sel_ext[ROW_W-1:0];
        end else if (row_ok) begin
            rd_addr = row_sum[ROW_W-1:0];
        end
    end

    // Write-back and result, on the commit edge.
    logic [LB-1:0] old_line, line_out, wr_data;
    logic          wr_en, hit;

    always_comb begin
        old_line = r_rd_valid ? r_rd_data : '0;
        hit      = |(old_line & r_mask);
        wr_data  = old_line ^ r_mask;
        wr_en    = 1'b0;
        n_acc    = r_acc;
        line_out = '0;
        case (r_op)
            xsf_pkg::OP_CLEAR: begin
            end
            xsf_pkg::OP_DRAW: begin
                if (r_idx_zero) n_acc = 1'b0;
                if (r_row_ok) begin
                    wr_en = 1'b1;
                    if (hit) n_acc = 1'b1;
                end
            end
            xsf_pkg::OP_READ: begin
                if (r_sel_ok) line_out = old_line;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op       <= i_req.opcode;
            r_idx_zero <= (i_req.row_index == 4'd0);
            r_row_ok   <= row_ok;
            r_sel_ok   <= sel_ok;
            r_mask     <= mask;
            r_addr     <= rd_addr;
            r_rd_data  <= mem[rd_addr];
            r_rd_valid <= r_line_valid[rd_addr];
        end
        if (i_cmd.commit && wr_en) begin
            mem[r_addr] <= wr_data;
        end
        if (i_cmd.commit) begin
            r_rsp.collision   <= n_acc;
            r_rsp.line_pixels <= line_out;
        end
    end

    // A line that is not valid reads as all pixels off; clear drops them all.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SCREEN_HEIGHT; i++) r_line_valid[i] <= 1'b0;
            r_acc <= 1'b0;
        end else if (i_cmd.commit) begin
            r_acc <= n_acc;
            if (r_op == xsf_pkg::OP_CLEAR) begin
                for (int i = 0; i < SCREEN_HEIGHT; i++) r_line_valid[i] <= 1'b0;
            end else if (wr_en) begin
                r_line_valid[r_addr] <= 1'b1;
            end
        end
    end

    assign o_rsp = r_rsp;

endmodule

`default_nettype wire

// ----- sv/xor_sprite_framebuffer_top.sv -----
// ----------------------------------------------------------------------------
// xor_sprite_framebuffer_top: one-bit display store with XOR sprite drawing
// Clears, draws one sprite row or reads one line per request.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                Payload
//  in       input      i_in_valid / o_in_stall  i_in_data  (t_in_req)
//  out      output     o_out_valid / i_out_stall o_out_data (t_out_rsp)
//
//  Every request is a read-modify-write: the accepting edge reads the
//  addressed line from the synchronous line memory, and the commit edge of the
//  modify state writes it back and loads the result register. That memory
//  read-modify-write sets the rate. Reset clears all per-line valid bits
//  together; there is no clearing pass. A new request is taken while a result
//  waits; its write-back then holds until the waiting result has been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module xor_sprite_framebuffer_top #(
    parameter int SCREEN_WIDTH  = xsf_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = xsf_pkg::SCREEN_HEIGHT_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  xsf_pkg::t_in_req  i_in_data,
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output xsf_pkg::t_out_rsp o_out_data
);

    xsf_pkg::t_ctrl_cmd cmd;

    xsf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    xsf_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_in_data),
        .o_rsp   (o_out_data)
    );

endmodule

`default_nettype wire
